[rtl/mtt_pkg.sv]
// Shared types and codes for the multi timer table.
`default_nettype none
package mtt_pkg;

  localparam int NUM_SLOTS_DEF = 64;

  localparam int OP_W    = 2;
  localparam int DELAY_W = 32;
  localparam int TAG_W   = 64;
  localparam int ID_W    = 8;
  localparam int KIND_W  = 3;
  localparam int MS_W    = 64;

  localparam logic [OP_W-1:0] OP_ARM  = 2'd0;
  localparam logic [OP_W-1:0] OP_KILL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ARMED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_KILLED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INVALID = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [DELAY_W-1:0] delay_ms;
    logic               periodic;
    logic [TAG_W-1:0]   user_tag;
    logic [ID_W-1:0]    timer_id;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   result_id;
    logic [TAG_W-1:0]  fired_tag;
    logic              last;
  } out_item_t;

  // One slot record as held in the slot memory.
  typedef struct packed {
    logic               periodic;
    logic [DELAY_W-1:0] period;
    logic [TAG_W-1:0]   tag;
    logic [MS_W-1:0]    due;
  } slot_rec_t;

  typedef struct packed {
    logic [MS_W-1:0] add_a;
    logic [MS_W-1:0] add_b;
    logic [MS_W-1:0] cmp_a;
    logic [MS_W-1:0] cmp_b;
  } alu_req_t;

  typedef struct packed {
    logic [MS_W-1:0] sum;
    logic            le;
  } alu_rsp_t;

endpackage
`default_nettype wire

[rtl/mtt_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire logic [WIDTH-1:0]    wdata,
  input  wire logic [AW-1:0]       raddr,
  output logic      [WIDTH-1:0]    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/mtt_alu.sv]
// Shared 64-bit adder and unsigned compare used by the arm, tick and scan steps.
`default_nettype none
module mtt_alu (
  input  wire mtt_pkg::alu_req_t req,
  output mtt_pkg::alu_rsp_t      rsp
);
  assign rsp.sum = req.add_a + req.add_b;
  assign rsp.le  = (req.cmp_a <= req.cmp_b);
endmodule
`default_nettype wire

[rtl/multi_timer_table_unit.sv]
// Top level of the multi timer table: sequencer, slot flags, time count and result register.
//
//   channel   ports                          direction  handshake
//   input     start, busy, in_item           in         taken when start && !busy
//   result    out_valid, out_item            out        one-cycle strobe, no back-pressure
//
// Arm: the free-slot search walks one slot per cycle.
// Kill: checks the id and clears its slot-used flag. Tick: one slot per cycle through the
// shared adder/compare, the slot memory read one slot ahead of the compare.
// Each result strobes the cycle after its step; the final one in the first cycle with busy low.
// Reset clears the time count and the slot-used flags at once; no sweep.
// The receiver cannot stall: a fired item is held back one firing so its last flag is known.
`default_nettype none
module multi_timer_table_unit #(
  parameter int NUM_SLOTS = mtt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mtt_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output mtt_pkg::out_item_t      out_item
);
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int REC_W = $bits(mtt_pkg::slot_rec_t);
  localparam int ID_W  = mtt_pkg::ID_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ARM, S_KILL, S_TICK, S_SCAN, S_FLUSH
  } state_t;

  state_t                      state_r, state_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  mtt_pkg::in_item_t           item_r, item_nxt;
  logic [mtt_pkg::MS_W-1:0]    cur_ms_r, cur_ms_nxt;
  logic [NUM_SLOTS-1:0]        used_r, used_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]             pend_id_r, pend_id_nxt;
  logic [mtt_pkg::TAG_W-1:0]   pend_tag_r, pend_tag_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mtt_pkg::out_item_t          out_item_r, out_item_nxt;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  mtt_pkg::slot_rec_t          ram_wrec, rd_rec;
  logic [REC_W-1:0]            ram_rdata;

  mtt_pkg::alu_req_t           alu_req;
  mtt_pkg::alu_rsp_t           alu_rsp;

  logic [ID_W-1:0]             slot_id;
  logic                        last_idx;
  logic [IDX_W-1:0]            kill_idx;
  logic [ID_W-1:0]             kill_m1;
  logic                        kill_bad;
  logic                        fire;
  logic [mtt_pkg::MS_W-1:0]    period_eff;

  mtt_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mtt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign rd_rec   = mtt_pkg::slot_rec_t'(ram_rdata);
  assign slot_id  = ID_W'(idx_r) + ID_W'(1);
  assign last_idx = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign kill_m1  = item_r.timer_id - ID_W'(1);
  assign kill_idx = kill_m1[IDX_W-1:0];
  assign kill_bad = (item_r.timer_id == '0) ||
                    ({1'b0, item_r.timer_id} > (ID_W + 1)'(NUM_SLOTS)) ||
                    !used_r[kill_idx];
  assign period_eff = (rd_rec.period == '0) ? mtt_pkg::MS_W'(1)
                                            : mtt_pkg::MS_W'(rd_rec.period);
  assign fire = used_r[idx_r] && alu_rsp.le;

  // operand select for the shared adder/compare
  always_comb begin
    alu_req.add_a = cur_ms_r;
    alu_req.cmp_a = rd_rec.due;
    alu_req.cmp_b = cur_ms_r;
    unique case (state_r)
      S_ARM:   alu_req.add_b = mtt_pkg::MS_W'(item_r.delay_ms);
      S_TICK:  alu_req.add_b = mtt_pkg::MS_W'(1);
      default: alu_req.add_b = period_eff;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    cur_ms_nxt    = cur_ms_r;
    used_nxt      = used_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    pend_tag_nxt  = pend_tag_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_raddr     = idx_r;
    ram_wrec      = rd_rec;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          idx_nxt  = '0;
          unique case (in_item.opcode)
            mtt_pkg::OP_ARM:  state_nxt = S_ARM;
            mtt_pkg::OP_KILL: state_nxt = S_KILL;
            mtt_pkg::OP_TICK: state_nxt = S_TICK;
            default:          state_nxt = S_IDLE;  // unused opcode: drop
          endcase
        end
      end

      S_ARM: begin
        if (!used_r[idx_r]) begin
          used_nxt[idx_r]   = 1'b1;
          ram_we            = 1'b1;
          ram_wrec.periodic = item_r.periodic;
          ram_wrec.period   = item_r.delay_ms;
          ram_wrec.tag      = item_r.user_tag;
          ram_wrec.due      = alu_rsp.sum;
          out_valid_nxt     = 1'b1;
          out_item_nxt      = '{kind: mtt_pkg::KIND_ARMED, result_id: slot_id,
                                fired_tag: '0, last: 1'b1};
          state_nxt         = S_IDLE;
        end else if (last_idx) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: mtt_pkg::KIND_FULL, result_id: '0,
                            fired_tag: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_KILL: begin
        out_valid_nxt = 1'b1;
        if (kill_bad) begin
          out_item_nxt = '{kind: mtt_pkg::KIND_INVALID, result_id: '0,
                           fired_tag: '0, last: 1'b1};
        end else begin
          used_nxt[kill_idx] = 1'b0;
          out_item_nxt = '{kind: mtt_pkg::KIND_KILLED, result_id: '0,
                           fired_tag: '0, last: 1'b1};
        end
        state_nxt = S_IDLE;
      end

      S_TICK: begin
        cur_ms_nxt    = alu_rsp.sum;
        ram_raddr     = '0;
        idx_nxt       = '0;
        pend_v_nxt    = 1'b0;
        state_nxt     = S_SCAN;
      end

      S_SCAN: begin
        // read one slot ahead while the current slot is compared
        ram_raddr = idx_r + IDX_W'(1);
        if (fire) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{kind: mtt_pkg::KIND_FIRED, result_id: pend_id_r,
                              fired_tag: pend_tag_r, last: 1'b0};
          end
          pend_v_nxt   = 1'b1;
          pend_id_nxt  = slot_id;
          pend_tag_nxt = rd_rec.tag;
          if (rd_rec.periodic) begin
            ram_we       = 1'b1;
            ram_wrec.due = alu_rsp.sum;
          end else begin
            used_nxt[idx_r] = 1'b0;
          end
        end
        if (last_idx) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_FLUSH: begin
        out_valid_nxt = 1'b1;
        if (pend_v_r) begin
          out_item_nxt = '{kind: mtt_pkg::KIND_FIRED, result_id: pend_id_r,
                           fired_tag: pend_tag_r, last: 1'b1};
        end else begin
          out_item_nxt = '{kind: mtt_pkg::KIND_NONE, result_id: '0,
                           fired_tag: '0, last: 1'b1};
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_ms_r    <= '0;
      used_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_ms_r    <= cur_ms_nxt;
      used_r      <= used_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    item_r     <= item_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_tag_r <= pend_tag_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_not_last_is_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> (out_item.kind == mtt_pkg::KIND_FIRED))
    else $error("non-final result is not a firing");

  a_fired_has_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind == mtt_pkg::KIND_FIRED) |-> (out_item.result_id != '0))
    else $error("fired result without an id");

  a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held firing left behind after a tick");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.opcode == mtt_pkg::OP_ARM ||
     in_item.opcode == mtt_pkg::OP_KILL || in_item.opcode == mtt_pkg::OP_TICK))
    |=> busy)
    else $error("accepted item did not start the sequencer");

  a_flush_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |=> (out_valid && out_item.last))
    else $error("tick ended without a final result");

endmodule
`default_nettype wire
